// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl of the yenc decoder
// no dependencies; expects a signal named clock and one named reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational or temporal property checked on every clock edge out of reset
`define YDC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define YDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ydc_pkg.sv =====
// package of the yenc decoder: codes, state and result types, crc byte fold
// no dependencies
package ydc_pkg;

   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [7:0]  PLAIN_BIAS  = 8'd42;
   localparam logic [7:0]  ESCAPE_BIAS = 8'd64;
   localparam logic [7:0]  ESC_CHAR    = 8'h3D;
   localparam logic [7:0]  CR_CHAR     = 8'h0D;
   localparam logic [7:0]  LF_CHAR     = 8'h0A;

   // running decoder state
   typedef struct packed {
      logic        escape;
      logic [31:0] crc;
   } ydc_state_type;

   // what one encoded byte gives
   typedef struct packed {
      logic        produce;
      logic        byte_valid;
      logic        segment_done;
      logic [7:0]  decoded;
      logic [31:0] crc_value;
   } ydc_result_type;

   // reflected crc-32 over one byte, lsb first
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/ydc_decoder.sv =====
// decode of one encoded byte: escape handling, bias removal, crc update
// depends on ydc_pkg
module ydc_decoder
   import ydc_pkg::*;
(
   input  ydc_state_type  state_cur,
   input  logic [7:0]     encoded_byte,
   input  logic           segment_last,
   output ydc_state_type  state_nxt,
   output ydc_result_type result
);

   logic        valid;
   logic        arm_escape;
   logic [7:0]  dec;
   logic [31:0] crc_upd;

   // classify the byte and remove the bias
   always_comb begin
      valid      = 1'b0;
      arm_escape = 1'b0;
      dec        = 8'd0;
      priority if (state_cur.escape) begin
         dec   = encoded_byte - PLAIN_BIAS - ESCAPE_BIAS;
         valid = 1'b1;
      end else if (encoded_byte == ESC_CHAR) begin
         arm_escape = 1'b1;
      end else if (encoded_byte == CR_CHAR || encoded_byte == LF_CHAR) begin
         // line breaks are dropped
         valid = 1'b0;
      end else begin
         dec   = encoded_byte - PLAIN_BIAS;
         valid = 1'b1;
      end
   end

   // fold the emitted byte into the crc
   assign crc_upd = valid ? crc_fold(state_cur.crc, dec) : state_cur.crc;

   // result fields and next state; segment end restores reset state
   always_comb begin
      result.produce      = valid | segment_last;
      result.byte_valid   = valid;
      result.segment_done = segment_last;
      result.decoded      = dec;
      result.crc_value    = segment_last ? (crc_upd ^ CRC_INIT) : 32'd0;
      if (segment_last) begin
         state_nxt.escape = 1'b0;
         state_nxt.crc    = CRC_INIT;
      end else begin
         state_nxt.escape = arm_escape;
         state_nxt.crc    = crc_upd;
      end
   end

endmodule

// ===== hw/rtl/yenc_decode_crc32_core.sv =====
// channel   ports      tdata fields (low bit up)              tuser / tlast
// req       req_*      encoded_byte[7:0]                      - / segment_last
// rsp       rsp_*      decoded_byte[7:0], crc_value[39:8]     byte_valid / segment_done
//
// one byte per cycle sustained while results are taken; a byte moves from the input register
// to the result register, the crc fold of one byte being done combinationally between input
// and result registers. cr, lf and unescaped '=' that are not a segment's last byte give no
// result and leave without waiting for the result side. a stalled result holds its
// register while one more byte is taken into the input register. reset is synchronous,
// clears the valid flags and the escape flag and sets the crc register to all ones.
// depends on ydc_pkg, ydc_decoder and assert_macros.svh
`include "assert_macros.svh"

module yenc_decode_crc32_core
   import ydc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // encoded_byte[7:0]
   input  logic        req_tlast,   // segment_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // decoded_byte[7:0], crc_value[39:8]
   output logic        rsp_tuser,   // byte_valid
   output logic        rsp_tlast    // segment_done
);

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   ydc_state_type  state_ff, state_in;
   ydc_result_type result;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic [7:0]     out_byte_ff;
   logic           out_bvalid_ff;
   logic           out_done_ff;
   logic [31:0]    out_crc_ff;
   logic           out_free;
   logic           advance;

   ydc_decoder u_decoder (
      .state_cur    (state_ff),
      .encoded_byte (in_byte_ff),
      .segment_last (in_last_ff),
      .state_nxt    (state_in),
      .result       (result)
   );

   // the held byte moves on if it gives nothing or the result register frees up
   assign out_free   = ~out_valid_ff | rsp_tready;
   assign advance    = in_valid_ff & (~result.produce | out_free);
   assign req_tready = ~in_valid_ff | advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.escape <= 1'b0;
         state_ff.crc    <= CRC_INIT;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_tready;
      if (advance && result.produce) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && result.produce) begin
         out_byte_ff   <= result.decoded;
         out_bvalid_ff <= result.byte_valid;
         out_done_ff   <= result.segment_done;
         out_crc_ff    <= result.crc_value;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_crc_ff, out_byte_ff};
   assign rsp_tuser  = out_bvalid_ff;
   assign rsp_tlast  = out_done_ff;

   // checks on the decoder's own behavior
   `YDC_ASSERT_NEXT(a_seg_end_clears, advance && in_last_ff,
      state_ff.crc == CRC_INIT && !state_ff.escape, "state not restored after segment end")
   `YDC_ASSERT(a_empty_only_last, !(rsp_tvalid && !rsp_tuser && !rsp_tlast),
      "empty result that is not a segment end")
   `YDC_ASSERT(a_crc_zero_midseg, !(rsp_tvalid && !rsp_tlast && rsp_tdata[39:8] != 32'd0),
      "crc field set on a result inside a segment")
   `YDC_ASSERT(a_byte_zero_empty, !(rsp_tvalid && !rsp_tuser && rsp_tdata[7:0] != 8'd0),
      "data byte set on a result without a byte")

endmodule

// ===== tb/sv/tb_yenc_decode_crc32_core.sv =====
// self-checking testbench of yenc_decode_crc32_core: yenc byte decoding with a crc-32
// per segment; a directed table, then random segments under changing stream back-pressure
// depends on ydc_pkg and the yenc_decode_crc32_core rtl
module tb_yenc_decode_crc32_core
   import ydc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF_NS   = 6;
   localparam int RESET_CYCLES    = 12;
   localparam int TOTAL_ITEMS     = 700;
   localparam int PHASE_TWO_AT    = 280;
   localparam int PHASE_THREE_AT  = 560;
   localparam int DRAIN_CYCLES    = 10;
   localparam int LIMIT_CYCLES    = 200_000;
   localparam int DIRECTED_COUNT  = 24;

   // one decoded result as seen on the rsp channel
   typedef struct packed {
      logic [7:0]  decoded;
      logic        byte_valid;
      logic        segment_done;
      logic [31:0] crc_value;
   } decoded_result_type;

   // one row of the directed table; typed rows carry their own expected result
   typedef struct packed {
      logic [7:0]         encoded;
      logic               last;
      logic               typed;
      decoded_result_type expected;
   } directed_row_type;

   localparam decoded_result_type NO_RESULT = '{8'h00, 1'b0, 1'b0, 32'h0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;     // encoded_byte[7:0]
   logic        req_tlast = 1'b0;      // segment_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;             // decoded_byte[7:0], crc_value[39:8]
   logic        rsp_tuser;             // byte_valid
   logic        rsp_tlast;             // segment_done

   // predictor state
   logic               escape_armed = 1'b0;
   logic [31:0]        running_crc = CRC_INIT;
   decoded_result_type pending_results[$];

   int error_count    = 0;
   int transfer_count = 0;
   int segment_count  = 0;
   int result_count   = 0;
   int send_idle_pct  = 29;
   int recv_idle_pct  = 73;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // cr as the only byte: empty segment, crc of nothing
      '{8'h0D, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 32'h0000_0000}},
      // trailing escape as the only byte
      '{8'h3D, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 32'h0000_0000}},
      // single byte decoding to zero
      '{8'h2A, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 32'hD202_EF8D}},
      // dropped lf and cr, then extremes of the plain path
      '{8'h0A, 1'b0, 1'b0, NO_RESULT},
      '{8'h0D, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      // escaped control bytes
      '{8'h3D, 1'b0, 1'b0, NO_RESULT},
      '{8'h0D, 1'b0, 1'b0, NO_RESULT},
      '{8'h3D, 1'b0, 1'b0, NO_RESULT},
      '{8'h0A, 1'b0, 1'b0, NO_RESULT},
      '{8'h3D, 1'b0, 1'b0, NO_RESULT},
      '{8'h3D, 1'b0, 1'b0, NO_RESULT},
      // extremes of the escaped path, then a plain byte
      '{8'h3D, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'h3D, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h55, 1'b0, 1'b0, NO_RESULT},
      // escaped last byte
      '{8'h3D, 1'b0, 1'b0, NO_RESULT},
      '{8'hAA, 1'b1, 1'b0, NO_RESULT},
      // escaped lf as the last byte
      '{8'h3D, 1'b0, 1'b0, NO_RESULT},
      '{8'h0A, 1'b1, 1'b0, NO_RESULT},
      // dropped lf as the last byte of a non-empty segment
      '{8'h41, 1'b0, 1'b0, NO_RESULT},
      '{8'h0A, 1'b1, 1'b0, NO_RESULT}
   };

   yenc_decode_crc32_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // run limit
   initial begin
      #(LIMIT_CYCLES * 2 * CLOCK_HALF_NS);
      $display("Test completed with failures");
      $finish;
   end

   // reflected crc-32, one data bit at a time, lsb first
   function automatic logic [31:0] crc32_add_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      logic        feedback;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         feedback = c[0] ^ data[i];
         c = (c >> 1) ^ (feedback ? CRC_POLY : 32'h0);
      end
      return c;
   endfunction

   // decode one encoded byte; returns 1 when the byte gives a result
   function automatic bit decode_byte(input logic [7:0] enc, input logic last,
                                      output decoded_result_type res);
      logic emit;
      logic [7:0] dec;
      emit = 1'b0;
      dec  = 8'h00;
      if (escape_armed) begin
         dec          = enc - PLAIN_BIAS - ESCAPE_BIAS;
         emit         = 1'b1;
         escape_armed = 1'b0;
      end else if (enc == ESC_CHAR) begin
         escape_armed = 1'b1;
      end else if (enc != CR_CHAR && enc != LF_CHAR) begin
         dec  = enc - PLAIN_BIAS;
         emit = 1'b1;
      end
      if (emit) running_crc = crc32_add_byte(running_crc, dec);
      res.decoded      = dec;
      res.byte_valid   = emit;
      res.segment_done = last;
      res.crc_value    = last ? (running_crc ^ CRC_INIT) : 32'h0;
      if (last) begin
         escape_armed = 1'b0;
         running_crc  = CRC_INIT;
      end
      return emit || last;
   endfunction

   // drive one byte, wait for its transfer, then predict its result
   task automatic send_byte(input logic [7:0] enc, input logic last, input logic typed,
                            input decoded_result_type typed_result, output bit produced);
      decoded_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= enc;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      produced = decode_byte(enc, last, predicted);
      if (produced) pending_results.push_back(typed ? typed_result : predicted);
      transfer_count++;
      if (last) segment_count++;
      // idling phases: sender-light, then receiver-light, then none
      if (transfer_count == PHASE_TWO_AT) begin
         send_idle_pct = 73;
         recv_idle_pct = 29;
      end else if (transfer_count == PHASE_THREE_AT) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // receiver back-pressure and result check
   always @(posedge clock) begin
      decoded_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (pending_results.size() == 0) begin
               $error("unexpected result transfer: data %h byte_valid %b segment_done %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[7:0] !== want.decoded) begin
                  $error("decoded_byte expected %h actual %h", want.decoded, rsp_tdata[7:0]);
                  error_count++;
               end
               if (rsp_tuser !== want.byte_valid) begin
                  $error("byte_valid expected %b actual %b", want.byte_valid, rsp_tuser);
                  error_count++;
               end
               if (rsp_tlast !== want.segment_done) begin
                  $error("segment_done expected %b actual %b", want.segment_done, rsp_tlast);
                  error_count++;
               end
               if (rsp_tdata[39:8] !== want.crc_value) begin
                  $error("crc_value expected %h actual %h", want.crc_value, rsp_tdata[39:8]);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // stimulus
   initial begin
      int  counted;
      int  seg_len;
      int  pick;
      bit  produced;
      logic [7:0] enc;

      counted = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].encoded, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].expected, produced);
         if (produced) counted++;
      end

      // random segments, mostly short, with a bias toward escape and line breaks
      while (transfer_count < TOTAL_ITEMS) begin
         seg_len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
         for (int k = 0; k < seg_len; k++) begin
            pick = $urandom_range(99);
            if (pick < 12)      enc = ESC_CHAR;
            else if (pick < 18) enc = CR_CHAR;
            else if (pick < 24) enc = LF_CHAR;
            else                enc = 8'($urandom_range(255));
            send_byte(enc, (k == seg_len - 1), 1'b0, NO_RESULT, produced);
            if (produced) counted++;
         end
      end
      req_tvalid <= 1'b0;

      // drain, then keep watching for stray results
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d encoded bytes in %0d segments sent, %0d results predicted, %0d checked",
               transfer_count, segment_count, counted, result_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
